/* design/mbp_pkg.sv */
// ----------------------------------------------------------------------------
// mbp_pkg
// Types and constants shared by the mosaic pixelation frame store modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbp_pkg;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BLOCK_LEVEL  = 2'd2;

  localparam int CFG_ADDR_W = 4;

  // Reset values of the configuration registers.
  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [9:0]  FRAME_HEIGHT_RST = 10'd480;
  localparam logic [2:0]  BLOCK_LEVEL_RST  = 3'd0;

  // Block side is 5 << (MAX_LEVEL - level), i.e. 160 >> level.
  localparam logic [2:0] MAX_LEVEL = 3'd5;

  // floor(v / 5) == (v * 205) >> 10 holds exactly for every v below 1024.
  localparam logic [17:0] DIV5_MUL   = 18'd205;
  localparam int          DIV5_SHIFT = 10;

  // Result queue behind the frame store read port.
  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_PTR_W = 2;
  localparam int OFIFO_CNT_W = 3;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_READ  = 1'b1
  } mbp_mode_t;

  // Control that travels with a request down the pipeline.
  typedef struct packed {
    logic vld;
    logic rd;
    logic outside;
  } mbp_ctl_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        outside;
  } mbp_result_t;

endpackage

/* design/mbp_frame_ram.sv */
// ----------------------------------------------------------------------------
// mbp_frame_ram
// Single-port synchronous frame store with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbp_frame_ram #(
  parameter int ADDR_W = 19,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* design/mbp_addr_gen.sv */
// ----------------------------------------------------------------------------
// mbp_addr_gen
// Frame check and block anchor address computation over two stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbp_addr_gen #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512,
  parameter int PIXEL_BITS = 32,
  parameter int X_W        = 10,
  parameter int Y_W        = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  mode,
  input  logic [9:0]            pos_x,
  input  logic [8:0]            pos_y,
  input  logic [31:0]           pixel_in,
  input  logic [10:0]           frame_width,
  input  logic [9:0]            frame_height,
  input  logic [2:0]            block_level,
  output mbp_pkg::mbp_ctl_t     ctl,
  output logic                  ram_we,
  output logic [X_W+Y_W-1:0]    ram_addr,
  output logic [PIXEL_BITS-1:0] ram_wdata
);

  import mbp_pkg::*;

  localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);

  // First stage: frame check and division of the coordinates by the side.
  logic [12:0] w_eff;
  logic [12:0] h_eff;
  logic        in_frame;
  logic [9:0]  hm1;
  logic [9:0]  from_bottom;
  logic [2:0]  lv;
  logic [2:0]  k;
  logic [17:0] qx_prod;
  logic [17:0] qy_prod;

  always_comb begin
    w_eff       = ({2'b0, frame_width} > MAXW) ? MAXW : {2'b0, frame_width};
    h_eff       = ({3'b0, frame_height} > MAXH) ? MAXH : {3'b0, frame_height};
    in_frame    = ({3'b0, pos_x} < w_eff) && ({4'b0, pos_y} < h_eff);
    hm1         = h_eff[9:0] - 10'd1;
    from_bottom = hm1 - {1'b0, pos_y};
    lv          = (block_level > MAX_LEVEL) ? MAX_LEVEL : block_level;
    k           = MAX_LEVEL - lv;
    qx_prod     = 18'(pos_x >> k) * DIV5_MUL;
    qy_prod     = 18'(from_bottom >> k) * DIV5_MUL;
  end

  mbp_ctl_t              s1_ctl;
  logic [2:0]            s1_k;
  logic [7:0]            s1_qx;
  logic [7:0]            s1_qy;
  logic [9:0]            s1_hm1;
  logic [9:0]            s1_x;
  logic [8:0]            s1_y;
  logic [PIXEL_BITS-1:0] s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl.vld     <= accept;
      s1_ctl.rd      <= (mode == MODE_READ);
      s1_ctl.outside <= !in_frame;
    end
    if (accept) begin
      s1_k   <= k;
      s1_qx  <= qx_prod[DIV5_SHIFT+7:DIV5_SHIFT];
      s1_qy  <= qy_prod[DIV5_SHIFT+7:DIV5_SHIFT];
      s1_hm1 <= hm1;
      s1_x   <= pos_x;
      s1_y   <= pos_y;
      s1_pix <= pixel_in[PIXEL_BITS-1:0];
    end
  end

  // Second stage: scale the block indexes back to pixel coordinates.
  logic [15:0] ax_full;
  logic [15:0] ay_full;
  logic [9:0]  ax;
  logic [9:0]  ay;

  always_comb begin
    ax_full   = (16'(s1_qx) * 16'd5) << s1_k;
    ay_full   = (16'(s1_qy) * 16'd5) << s1_k;
    ax        = ax_full[9:0];
    ay        = s1_hm1 - ay_full[9:0];
    ctl       = s1_ctl;
    ram_we    = s1_ctl.vld && !s1_ctl.rd && !s1_ctl.outside;
    ram_addr  = s1_ctl.rd ? {Y_W'(ay), X_W'(ax)} : {Y_W'(s1_y), X_W'(s1_x)};
    ram_wdata = s1_pix;
  end

endmodule

/* design/mbp_out_fifo.sv */
// ----------------------------------------------------------------------------
// mbp_out_fifo
// Small result queue that decouples the read pipeline from the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbp_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mbp_pkg::mbp_result_t push_data,
  input  logic                 pop,
  output logic                 not_empty,
  output mbp_pkg::mbp_result_t head
);

  import mbp_pkg::*;

  mbp_result_t            entries [OFIFO_DEPTH];
  logic [OFIFO_PTR_W-1:0] wr_ptr;
  logic [OFIFO_PTR_W-1:0] rd_ptr;
  logic [OFIFO_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + OFIFO_CNT_W'(push) - OFIFO_CNT_W'(pop);
    end
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

endmodule

/* design/mosaic_block_pixelate_unit.sv */
// ----------------------------------------------------------------------------
// mosaic_block_pixelate_unit
// A read passes the stage one and store read registers and the result queue.
// Throughput: one request per cycle while in_ready is high, set by the single
//   store port that every request uses exactly once. Writes give no result.
// Reset: control and configuration registers reset; the frame store is not
//   cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mosaic_block_pixelate_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512,
  parameter int PIXEL_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // Request channel.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            mode,
  input  logic [9:0]                      pos_x,
  input  logic [8:0]                      pos_y,
  input  logic [31:0]                     pixel_in,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     pixel_out,
  output logic                            outside_frame,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mbp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  import mbp_pkg::*;

  localparam int X_W = $clog2(MAX_WIDTH);
  localparam int Y_W = $clog2(MAX_HEIGHT);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are taken on the access phase only; the
  // low two address bits are ignored, and writes to index three are dropped.
  // --------------------------------------------------------------------------
  logic [10:0] frame_width;
  logic [9:0]  frame_height;
  logic [2:0]  block_level;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      block_level  <= BLOCK_LEVEL_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        CFG_FRAME_WIDTH:  frame_width  <= pwdata[10:0];
        CFG_FRAME_HEIGHT: frame_height <= pwdata[9:0];
        CFG_BLOCK_LEVEL:  block_level  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      CFG_FRAME_WIDTH:  prdata = {21'b0, frame_width};
      CFG_FRAME_HEIGHT: prdata = {22'b0, frame_height};
      CFG_BLOCK_LEVEL:  prdata = {29'b0, block_level};
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control. Every read request that is in the pipeline or waiting in
  // the result queue holds one queue slot, so the queue can never overflow
  // and the frame store pipeline never has to stall. With the output side
  // taking one result per cycle, at most three slots are held and a new
  // request is taken every cycle.
  // --------------------------------------------------------------------------
  logic                   accept;
  logic                   pop;
  logic [OFIFO_CNT_W-1:0] pending;

  assign in_ready = (pending < OFIFO_CNT_W'(OFIFO_DEPTH));
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + OFIFO_CNT_W'(accept && (mode == MODE_READ))
                 - OFIFO_CNT_W'(pop);
    end
  end

  // --------------------------------------------------------------------------
  // Address generation: stage one checks the frame and divides the position
  // by the block side, stage two forms the anchor address of a read and drives the
  // frame store. Writes and reads reach the store in request order through
  // the one port, so a read always sees every earlier write.
  // --------------------------------------------------------------------------
  mbp_ctl_t              a_ctl;
  logic                  ram_we;
  logic [X_W+Y_W-1:0]    ram_addr;
  logic [PIXEL_BITS-1:0] ram_wdata;
  logic [PIXEL_BITS-1:0] ram_rdata;

  mbp_addr_gen #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS),
    .X_W        (X_W),
    .Y_W        (Y_W)
  ) u_addr_gen (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .mode         (mode),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pixel_in     (pixel_in),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .block_level  (block_level),
    .ctl          (a_ctl),
    .ram_we       (ram_we),
    .ram_addr     (ram_addr),
    .ram_wdata    (ram_wdata)
  );

  mbp_frame_ram #(
    .ADDR_W (X_W + Y_W),
    .DATA_W (PIXEL_BITS)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Read data stage. The control travels alongside the registered read data;
  // a position outside the frame gives zero regardless of what was read.
  // --------------------------------------------------------------------------
  mbp_ctl_t    s2_ctl;
  mbp_result_t push_data;
  mbp_result_t head;
  logic        push;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else begin
      s2_ctl <= a_ctl;
    end
  end

  assign push              = s2_ctl.vld && s2_ctl.rd;
  assign push_data.pixel   = s2_ctl.outside ? 32'd0 : 32'(ram_rdata);
  assign push_data.outside = s2_ctl.outside;

  mbp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (out_valid),
    .head      (head)
  );

  assign pixel_out     = head.pixel;
  assign outside_frame = head.outside;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= OFIFO_CNT_W'(OFIFO_DEPTH))
    else $error("pending read count exceeds result queue depth");

  a_read_enters: assert property (@(posedge clk) disable iff (rst)
    accept && (mode == MODE_READ) |=> a_ctl.vld && a_ctl.rd)
    else $error("accepted read did not enter the address stage");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("queued result not presented on the output");

  a_result_owned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("result present without a pending read");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && outside_frame |-> pixel_out == 32'd0)
    else $error("outside position returned nonzero pixel");

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the mosaic pixelation frame store. Write and read
// requests go in through the valid/ready request channel, and the frame
// size and block level are set over the APB-style port. A scoreboard keeps
// its own copy of the frame and predicts each mosaic pixel. Both channels
// stall at random, and the run steps through a series of frame settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mbp_pkg::*;

  localparam int FRAME_MAX_W = 1024;
  localparam int FRAME_MAX_H = 512;
  localparam int BLOCK_BASE  = 160;
  localparam int SETTINGS_N  = 9;

  // Scoreboard: a shadow of the registers and of every pixel written so far,
  // and the queue of mosaic pixels still owed by the block.
  class pixelate_checker;
    bit [10:0]   width_reg;
    bit [9:0]    height_reg;
    bit [2:0]    level_reg;
    bit [31:0]   frame_copy [int];
    mbp_result_t owed_pixels [$];
    int          mismatches;
    int          requests;
    int          results;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      level_reg  = BLOCK_LEVEL_RST;
    endfunction

    function void set_reg(logic [1:0] idx, bit [31:0] value);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg  = value[10:0];
        CFG_FRAME_HEIGHT: height_reg = value[9:0];
        CFG_BLOCK_LEVEL:  level_reg  = value[2:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] reg_value(logic [1:0] idx);
      case (idx)
        CFG_FRAME_WIDTH:  return {21'd0, width_reg};
        CFG_FRAME_HEIGHT: return {22'd0, height_reg};
        CFG_BLOCK_LEVEL:  return {29'd0, level_reg};
        default:          return 32'd0;
      endcase
    endfunction

    // Sizes above the store limits are clipped to the store.
    function int eff_w();
      return (width_reg > FRAME_MAX_W) ? FRAME_MAX_W : int'(width_reg);
    endfunction

    function int eff_h();
      return (height_reg > FRAME_MAX_H) ? FRAME_MAX_H : int'(height_reg);
    endfunction

    function bit covers(int x, int y);
      return (x < eff_w()) && (y < eff_h());
    endfunction

    // Levels six and seven act as level five.
    function int side();
      return BLOCK_BASE >> ((level_reg > MAX_LEVEL) ? MAX_LEVEL : level_reg);
    endfunction

    // Block rows are counted up from the bottom row; columns from x = 0.
    function void anchor_of(int x, int y, output int ax, output int ay);
      int s;
      int h;
      int up;
      s  = side();
      h  = eff_h();
      up = (h - 1) - y;
      ay = (h - 1) - (up / s) * s;
      ax = (x / s) * s;
    endfunction

    function void note(string what, logic [31:0] exp_v, logic [31:0] act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, act_v);
    endfunction

    function void take_request(mbp_mode_t m, bit [9:0] x, bit [8:0] y, bit [31:0] p);
      mbp_result_t r;
      int ax;
      int ay;
      requests++;
      if (m == MODE_WRITE) begin
        // Writes outside the frame are dropped.
        if (covers(x, y))
          frame_copy[y * FRAME_MAX_W + x] = p;
        return;
      end
      if (!covers(x, y)) begin
        r.pixel   = 32'd0;
        r.outside = 1'b1;
      end else begin
        anchor_of(x, y, ax, ay);
        r.pixel   = frame_copy.exists(ay * FRAME_MAX_W + ax) ?
                    frame_copy[ay * FRAME_MAX_W + ax] : 32'd0;
        r.outside = 1'b0;
      end
      owed_pixels.push_back(r);
    endfunction

    function void compare_result(logic [31:0] px, logic outside);
      mbp_result_t e;
      results++;
      if (owed_pixels.size() == 0) begin
        note("unexpected result", 32'd0, px);
        return;
      end
      e = owed_pixels.pop_front();
      if (px !== e.pixel)
        note("pixel_out", e.pixel, px);
      if (outside !== e.outside)
        note("outside_frame", {31'd0, e.outside}, {31'd0, outside});
    endfunction

    function int pending();
      return owed_pixels.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  mode      = 1'b0;
  logic [9:0]            pos_x     = '0;
  logic [8:0]            pos_y     = '0;
  logic [31:0]           pixel_in  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [31:0]           pixel_out;
  logic                  outside_frame;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [31:0]           pwdata    = '0;
  logic [31:0]           prdata;
  logic                  pready;

  pixelate_checker mosaic_chk = new();

  // Pixels whose value is known since the last change of frame size. Reads
  // are only issued once their block anchor is in this set.
  bit written [int];

  // Percent of cycles in which the request side and the result side idle.
  int tx_idle_pct = 27;
  int rx_idle_pct = 70;

  int set_w  [SETTINGS_N] = '{1024, 1, 2047, 0, 100, 333, 640, 0, 1024};
  int set_h  [SETTINGS_N] = '{512,  1, 1023, 0, 37,  250, 480, 0, 1};
  int set_lv [SETTINGS_N] = '{5,    0, 7,    6, 3,   4,   1,   0, 2};

  mosaic_block_pixelate_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pixel_in      (pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_out     (pixel_out),
    .outside_frame (outside_frame),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The result side stalls at random, independent of the request side.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Both handshakes are sampled on the edge with the values from before it.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        mosaic_chk.take_request(mbp_mode_t'(mode), pos_x, pos_y, pixel_in);
      if (out_valid && out_ready)
        mosaic_chk.compare_result(pixel_out, outside_frame);
    end
  end

  // Offers one request, with a random idle gap in front of it, and returns at
  // the edge that accepts it. Valid stays high into the next request when no
  // gap is drawn, so it is never dropped and raised in the same step.
  task automatic send_req(mbp_mode_t m, bit [9:0] x, bit [8:0] y, bit [31:0] p);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    mode     <= m;
    pos_x    <= x;
    pos_y    <= y;
    pixel_in <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_pixel(int x, int y, bit [31:0] p);
    if (mosaic_chk.covers(x, y))
      written[y * FRAME_MAX_W + x] = 1'b1;
    send_req(MODE_WRITE, x[9:0], y[8:0], p);
  endtask

  // Reads one mosaic pixel. When the block anchor has no known value yet, the
  // anchor is written first, so the read always has a defined answer.
  task automatic read_block(int x, int y);
    int ax;
    int ay;
    if (mosaic_chk.covers(x, y)) begin
      mosaic_chk.anchor_of(x, y, ax, ay);
      if (!written.exists(ay * FRAME_MAX_W + ax))
        send_pixel(ax, ay, $urandom);
    end
    send_req(MODE_READ, x[9:0], y[8:0], $urandom);
  endtask

  // Holds off new requests until every owed result is back, then lets the
  // pipeline empty of writes, which give no result.
  task automatic drain();
    in_valid <= 1'b0;
    while (mosaic_chk.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reg_verify(logic [1:0] idx);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== mosaic_chk.reg_value(idx))
      mosaic_chk.note("register readback", mosaic_chk.reg_value(idx), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Register writes happen only with the block drained. A new frame size
  // makes every stored pixel stale for the purpose of choosing reads.
  task automatic reg_write(logic [1:0] idx, bit [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    mosaic_chk.set_reg(idx, value);
    if (idx != CFG_BLOCK_LEVEL)
      written.delete();
    reg_verify(idx);
  endtask

  // Mostly well-formed traffic: a pixel somewhere in the frame, often on an
  // edge, read after its anchor is known. The rest is plain writes, reads
  // outside the frame and writes anywhere in the full coordinate range.
  task automatic run_random(int n);
    int w;
    int h;
    int x;
    int y;
    int ax;
    int ay;
    int r;
    for (int i = 0; i < n; i++) begin
      w = mosaic_chk.eff_w();
      h = mosaic_chk.eff_h();
      r = $urandom_range(99);
      if (r < 60 && w > 0 && h > 0) begin
        x = ($urandom_range(3) == 0) ? ($urandom_range(1) ? w - 1 : 0) : $urandom_range(w - 1);
        y = ($urandom_range(3) == 0) ? ($urandom_range(1) ? h - 1 : 0) : $urandom_range(h - 1);
        if ($urandom_range(3) == 0) begin
          mosaic_chk.anchor_of(x, y, ax, ay);
          send_pixel(ax, ay, $urandom);
        end
        read_block(x, y);
      end else if (r < 75 && w > 0 && h > 0) begin
        send_pixel($urandom_range(w - 1), $urandom_range(h - 1), $urandom);
      end else if (r < 90) begin
        if (w < FRAME_MAX_W && (h == FRAME_MAX_H || $urandom_range(1))) begin
          x = $urandom_range(FRAME_MAX_W - 1, w);
          y = $urandom_range(FRAME_MAX_H - 1);
        end else if (h < FRAME_MAX_H) begin
          x = $urandom_range(FRAME_MAX_W - 1);
          y = $urandom_range(FRAME_MAX_H - 1, h);
        end else begin
          // The frame fills the store, so this lands inside it.
          x = $urandom_range(FRAME_MAX_W - 1);
          y = $urandom_range(FRAME_MAX_H - 1);
        end
        read_block(x, y);
      end else begin
        send_pixel($urandom_range(FRAME_MAX_W - 1), $urandom_range(FRAME_MAX_H - 1), $urandom);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset values of all registers.
    reg_verify(CFG_FRAME_WIDTH);
    reg_verify(CFG_FRAME_HEIGHT);
    reg_verify(CFG_BLOCK_LEVEL);

    // Directed requests on the reset frame of 640 by 480 with 160 pixel
    // blocks. Anchor rows are 479, 319 and 159; anchor columns step by 160.
    send_pixel(0, 479, 32'h0000_0000);
    send_pixel(480, 159, 32'hFFFF_FFFF);
    send_pixel(639, 0, 32'hA5A5_A5A5);
    send_pixel(160, 319, 32'h8000_0001);
    read_block(0, 479);
    read_block(159, 320);
    // Top right corner repeats the anchor below it, not its own pixel.
    read_block(639, 0);
    read_block(480, 159);
    read_block(170, 160);
    // Reads just past each edge and at the far corner come back flagged.
    read_block(640, 0);
    read_block(0, 480);
    read_block(1023, 511);
    // A write outside the frame is dropped and gives no result.
    send_pixel(1023, 511, 32'h1234_5678);
    send_pixel(639, 479, 32'h5A5A_5A5A);
    send_pixel(480, 479, 32'h0000_0001);
    read_block(639, 479);
    // Overwriting an anchor changes the whole block.
    send_pixel(480, 479, 32'hFFFF_FFFE);
    read_block(500, 400);
    read_block(639, 479);

    // Settings run from the largest frame with the smallest blocks, through
    // the smallest frame, oversized sizes with a saturating level and an
    // empty frame, to ordinary and random sizes.
    for (int k = 0; k < SETTINGS_N; k++) begin
      if (k == 3) begin
        tx_idle_pct = 70;
        rx_idle_pct = 27;
      end
      if (k == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      drain();
      if (k == 7) begin
        reg_write(CFG_FRAME_WIDTH, $urandom_range(FRAME_MAX_W, 1));
        reg_write(CFG_FRAME_HEIGHT, $urandom_range(FRAME_MAX_H, 1));
        reg_write(CFG_BLOCK_LEVEL, $urandom_range(7));
      end else begin
        reg_write(CFG_FRAME_WIDTH, set_w[k]);
        reg_write(CFG_FRAME_HEIGHT, set_h[k]);
        reg_write(CFG_BLOCK_LEVEL, set_lv[k]);
      end
      run_random(15);
      // The request side pauses here until every owed result has come back.
      drain();
      run_random(15);
    end
    drain();

    $display("Checked %0d results from %0d requests over %0d frame settings,",
             mosaic_chk.results, mosaic_chk.requests, SETTINGS_N + 1);
    $display("with both sides stalling at random and then running without gaps.");
    if (mosaic_chk.mismatches == 0 && mosaic_chk.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
